// ===== hdl/multichannel_pcm_mixer_macros.svh =====
// Assertion macros for the PCM mixer.
// Define NO_ASSERTIONS to compile them away.
`ifndef MULTICHANNEL_PCM_MIXER_MACROS_SVH
`define MULTICHANNEL_PCM_MIXER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MIX_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MIX_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MIX_ASSERT_IMP(label, clk, rst, ante, cons)
`define MIX_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/mpm_pkg.sv =====
// Package of the PCM mixer: payload structs, command codes, state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mpm_pkg;
   typedef enum logic [2:0] {
      FUNC_TICK = 3'd0, FUNC_WRITE = 3'd1, FUNC_LOAD = 3'd2, FUNC_PLAY = 3'd3,
      FUNC_PAUSE = 3'd4, FUNC_STOP = 3'd5, FUNC_QUERY = 3'd6, FUNC_NONE = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_MUL, ST_ACC, ST_DONE, ST_OUT
   } state_type;

   localparam logic [0:0] CSR_MASTER_GAIN = 1'b0;
   localparam logic [0:0] CSR_ACTIVE = 1'b1;

   typedef struct packed {
      logic [2:0]         func;
      logic [15:0]        sample_address;
      logic signed [15:0] sample_value;
      logic [16:0]        sound_length;
      logic [15:0]        gain_l;
      logic [15:0]        gain_r;
      logic               loop_flag;
      logic               start_now;
      logic [3:0]         channel_select;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic [3:0]         channel_out;
      logic               ok;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hdl/multichannel_pcm_mixer.sv =====
// A command other than a tick passes from acceptance through READ and DONE back
// to IDLE. A tick walks min(active_channels, CHANNELS) slots, each slot passing
// through READ (channel table read), MUL (sample memory read), ACC (gain
// multiply) and OUT (master multiply and accumulate); the tick then ends with
// READ and DONE. The channel table and sample memory are synchronous RAMs; valid
// bits in flip-flops mark loaded slots.
// Results are held in an output register; a new request is accepted in the cycle
// the held response is taken or later, and waits while that response is stalled.
// Depends on mpm_pkg and multichannel_pcm_mixer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_pcm_mixer_macros.svh"
module multichannel_pcm_mixer #(
   parameter int CHANNELS     = 16,
   parameter int SAMPLE_WORDS = 65536,
   parameter int SAMPLE_BITS  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire mpm_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      mpm_pkg::rsp_type rsp_data,
   input  wire logic             csr_write,
   input  wire logic             csr_index,
   input  wire logic [15:0]      csr_wdata
);
   import mpm_pkg::*;

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW = $clog2(SAMPLE_WORDS);
   localparam int EW = 17 + 17 + 16 + 1;  // position, length, start, loop
   localparam int TW = EW + 32;           // plus gains
   localparam int PW = SAMPLE_BITS + 17;  // sample times slot gain

   // Sample memory.
   logic signed [SAMPLE_BITS-1:0] smem [SAMPLE_WORDS];
   logic        [AW-1:0]          smem_raddr;
   logic signed [SAMPLE_BITS-1:0] smem_rd_ff;
   logic                          smem_we;
   logic        [AW-1:0]          smem_waddr;
   logic signed [SAMPLE_BITS-1:0] smem_wdata;

   always_ff @(posedge clock) begin
      if (smem_we) begin
         smem[smem_waddr] <= smem_wdata;
      end
      smem_rd_ff <= smem[smem_raddr];
   end

   // Channel table memory: {gains, loop, start, length, position}.
   logic [TW-1:0] ctab [CHANNELS];
   logic [CW-1:0] ctab_raddr;
   logic [TW-1:0] ctab_rd_ff;
   logic          ctab_we;
   logic [CW-1:0] ctab_waddr;
   logic [TW-1:0] ctab_wdata;

   always_ff @(posedge clock) begin
      if (ctab_we) begin
         ctab[ctab_waddr] <= ctab_wdata;
      end
      ctab_rd_ff <= ctab[ctab_raddr];
   end

   // Registers.
   logic [15:0]          master_ff, master_in;
   logic [4:0]           active_ff, active_in;
   logic [CHANNELS-1:0]  loaded_ff, loaded_in;
   logic [CHANNELS-1:0]  playing_ff, playing_in;
   logic [15:0]          start_ff [CHANNELS];   // compare copy for stop/query
   logic [15:0]          start_in [CHANNELS];
   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [CW:0]          idx_ff, idx_in;
   logic signed [63:0]   accl_ff, accl_in, accr_ff, accr_in;
   logic signed [PW-1:0] pl_ff, pl_in, pr_ff, pr_in;
   logic                 act_ff, act_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= 16'd32768;
         active_ff    <= 5'd16;
         loaded_ff    <= '0;
         playing_ff   <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         master_ff    <= master_in;
         active_ff    <= active_in;
         loaded_ff    <= loaded_in;
         playing_ff   <= playing_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff <= start_in;
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      accl_ff  <= accl_in;
      accr_ff  <= accr_in;
      pl_ff    <= pl_in;
      pr_ff    <= pr_in;
      act_ff   <= act_in;
      rsp_ff   <= rsp_in;
   end

   // Unpacked view of the channel entry read.
   logic [15:0]  e_lg, e_rg, e_start;
   logic         e_loop;
   logic [16:0]  e_len, e_pos, e_pos1;
   logic [AW-1:0] e_addr;
   assign e_rg    = ctab_rd_ff[TW-1 -: 16];
   assign e_lg    = ctab_rd_ff[TW-17 -: 16];
   assign e_loop  = ctab_rd_ff[EW-1];
   assign e_start = ctab_rd_ff[EW-2 -: 16];
   assign e_len   = ctab_rd_ff[33:17];
   assign e_pos   = ctab_rd_ff[16:0];
   assign e_pos1  = e_pos + 17'd1;
   assign e_addr  = AW'((34)'(e_start) + (34)'(e_pos));

   logic [CW:0] nslots;
   logic [CW:0] cur;
   logic        accept;
   logic        free_found;
   logic [CW-1:0] free_idx;
   logic [CW-1:0] sel_idx;
   logic        match_any;
   logic [CHANNELS-1:0] match_vec;
   logic signed [63:0]  fl, fr;
   logic signed [15:0]  satl, satr;

   always_comb begin
      if ({27'd0, active_ff} > CHANNELS) nslots = (CW+1)'(CHANNELS);
      else nslots = (CW+1)'(active_ff);
   end

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign sel_idx   = CW'(req_ff.channel_select);

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      match_vec  = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (i < int'(nslots) && !loaded_ff[i]) begin
            free_found = 1'b1;
            free_idx   = CW'(i);
         end
         match_vec[i] = (i < int'(nslots)) && loaded_ff[i]
                        && (start_ff[i] == req_ff.sample_address);
      end
      match_any = |match_vec;
   end

   // Floor shift then saturate.
   assign fl = accl_ff >>> 30;
   assign fr = accr_ff >>> 30;
   always_comb begin
      satl = (fl > 64'sd32767) ? 16'sh7FFF : (fl < -64'sd32768) ? 16'sh8000 : fl[15:0];
      satr = (fr > 64'sd32767) ? 16'sh7FFF : (fr < -64'sd32768) ? 16'sh8000 : fr[15:0];
   end

   assign cur = idx_ff;

   always_comb begin
      master_in    = master_ff;
      active_in    = active_ff;
      loaded_in    = loaded_ff;
      playing_in   = playing_ff;
      start_in     = start_ff;
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      accl_in      = accl_ff;
      accr_in      = accr_ff;
      pl_in        = pl_ff;
      pr_in        = pr_ff;
      act_in       = act_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      smem_we      = 1'b0;
      smem_waddr   = AW'(req_ff.sample_address);
      smem_wdata   = SAMPLE_BITS'(req_ff.sample_value);
      smem_raddr   = e_addr;
      ctab_we      = 1'b0;
      ctab_waddr   = cur[CW-1:0];
      ctab_wdata   = ctab_rd_ff;
      ctab_raddr   = cur[CW-1:0];

      if (csr_write) begin
         case (csr_index)
            CSR_MASTER_GAIN: master_in = csr_wdata;
            CSR_ACTIVE:      active_in = csr_wdata[4:0];
            default:         ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               idx_in  = '0;
               accl_in = '0;
               accr_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // Table read for slot cur issued here; non-tick commands finish.
            if (req_ff.func == FUNC_TICK) begin
               if (cur >= nslots) begin
                  state_in = ST_DONE;
               end else begin
                  act_in   = loaded_ff[cur[CW-1:0]] && playing_ff[cur[CW-1:0]];
                  state_in = ST_MUL;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            // Entry data ready; start sample read, write back position.
            state_in = ST_ACC;
            if (act_ff) begin
               if (e_pos < e_len) begin
                  if (e_pos1 >= e_len) begin
                     if (e_loop) ctab_wdata[16:0] = '0;
                     else begin
                        loaded_in[cur[CW-1:0]]  = 1'b0;
                        playing_in[cur[CW-1:0]] = 1'b0;
                     end
                  end else ctab_wdata[16:0] = e_pos1;
                  ctab_we = 1'b1;
               end else begin
                  act_in = 1'b0;
                  if (!e_loop) begin
                     loaded_in[cur[CW-1:0]]  = 1'b0;
                     playing_in[cur[CW-1:0]] = 1'b0;
                  end
               end
            end
         end
         ST_ACC: begin
            // Sample ready: gain products (sample times unsigned 16-bit gain).
            pl_in = act_ff ? PW'(smem_rd_ff * $signed({1'b0, e_lg})) : '0;
            pr_in = act_ff ? PW'(smem_rd_ff * $signed({1'b0, e_rg})) : '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            accl_in = accl_ff + 64'(pl_ff * $signed({1'b0, master_ff}));
            accr_in = accr_ff + 64'(pr_ff * $signed({1'b0, master_ff}));
            idx_in  = idx_ff + 1'b1;
            ctab_raddr = CW'(idx_ff + 1'b1);
            state_in = ST_READ;
         end
         ST_DONE: begin
            rsp_in = '0;
            case (req_ff.func)
               FUNC_TICK: begin
                  rsp_in.left_out  = satl;
                  rsp_in.right_out = satr;
                  rsp_in.ok        = 1'b1;
               end
               FUNC_WRITE: begin
                  smem_we   = 1'b1;
                  rsp_in.ok = 1'b1;
               end
               FUNC_LOAD: begin
                  if (free_found) begin
                     loaded_in[free_idx]  = 1'b1;
                     playing_in[free_idx] = req_ff.start_now;
                     start_in[free_idx]   = req_ff.sample_address;
                     ctab_we    = 1'b1;
                     ctab_waddr = free_idx;
                     ctab_wdata = {req_ff.gain_r, req_ff.gain_l, req_ff.loop_flag,
                                   req_ff.sample_address, req_ff.sound_length, 17'd0};
                     rsp_in.channel_out = 4'(free_idx);
                     rsp_in.ok = 1'b1;
                  end
               end
               FUNC_PLAY, FUNC_PAUSE: begin
                  if ({28'd0, req_ff.channel_select} < 32'(nslots)
                      && loaded_ff[sel_idx]) begin
                     playing_in[sel_idx] = (req_ff.func == FUNC_PLAY);
                     rsp_in.ok = 1'b1;
                  end
               end
               FUNC_STOP: begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     if (match_vec[i]) begin
                        loaded_in[i]  = 1'b0;
                        playing_in[i] = 1'b0;
                     end
                  end
                  rsp_in.ok = match_any;
               end
               FUNC_QUERY: rsp_in.ok = match_any;
               default: ;
            endcase
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `MIX_ASSERT_IMP(a_busy_stalls, clock, reset, state_ff != ST_IDLE, req_stall)
   `MIX_ASSERT_NXT(a_done_valid, clock, reset, state_ff == ST_DONE, rsp_valid)
   `MIX_ASSERT_IMP(a_play_loaded, clock, reset, 1'b1, (playing_ff & ~loaded_ff) == '0)
endmodule
`default_nettype wire
